// ===== hdl/lscs_pkg.sv =====
// Shared types and constants for the line sensor calibrating slave.
// Holds command codes, response bytes, pattern and direction codes.
// No dependencies.
`default_nettype none

package lscs_pkg;

  localparam int SAMPLE_WIDTH_DEF = 10;
  localparam int NUM_CH           = 3;
  localparam int CH_IDX_W         = $clog2(NUM_CH);
  localparam int BYTE_W           = 8;
  localparam int PAT_W            = NUM_CH;
  localparam int DIR_W            = 3;

  localparam logic [BYTE_W-1:0] CMD_PING      = 8'h00;
  localparam logic [BYTE_W-1:0] CMD_CH_FIRST  = 8'h10;
  localparam logic [BYTE_W-1:0] CMD_CH_LAST   = 8'h15;
  localparam logic [BYTE_W-1:0] CMD_CALIBRATE = 8'h37;

  localparam logic [BYTE_W-1:0] RESP_ACK   = 8'hFF;
  localparam logic [BYTE_W-1:0] RESP_RESET = 8'h30;

  localparam logic [PAT_W-1:0] PAT_LOST     = 3'b000;
  localparam logic [PAT_W-1:0] PAT_STRAIGHT = 3'b010;
  localparam logic [PAT_W-1:0] PAT_RIGHT    = 3'b011;
  localparam logic [PAT_W-1:0] PAT_LEFT     = 3'b110;
  localparam logic [PAT_W-1:0] PAT_CROSS    = 3'b111;

  typedef enum logic [DIR_W-1:0] {
    DIR_NONE     = 3'd0,
    DIR_LOST     = 3'd1,
    DIR_STRAIGHT = 3'd2,
    DIR_RIGHT    = 3'd3,
    DIR_LEFT     = 3'd4,
    DIR_CROSS    = 3'd5
  } dir_t;

  typedef struct packed {
    logic accept;
    logic calibrate;
  } xfer_ctl_t;

endpackage

`default_nettype wire

// ===== hdl/lscs_lane.sv =====
// One sensor lane: running min, max and midpoint threshold of a channel.
// Reports whether the current sample lies above the stored threshold.
// Depends on lscs_pkg.
`default_nettype none

module lscs_lane #(
  parameter int SAMPLE_WIDTH = lscs_pkg::SAMPLE_WIDTH_DEF
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire lscs_pkg::xfer_ctl_t     ctl,
  input  wire logic [SAMPLE_WIDTH-1:0] sample,
  output logic                         above
);

  logic [SAMPLE_WIDTH:0]   min_r, min_nxt;
  logic [SAMPLE_WIDTH-1:0] max_r, max_nxt;
  logic [SAMPLE_WIDTH-1:0] thr_r, thr_nxt;
  logic [SAMPLE_WIDTH+1:0] sum;
  logic [SAMPLE_WIDTH:0]   sample_ext;

  assign sample_ext = {1'b0, sample};
  assign above      = (sample > thr_r);

  always_comb begin
    min_nxt = (sample_ext < min_r) ? sample_ext : min_r;
    max_nxt = (sample > max_r) ? sample : max_r;
    sum     = {1'b0, min_nxt} + {2'b00, max_nxt};
    thr_nxt = sum[SAMPLE_WIDTH:1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_r <= {1'b1, {SAMPLE_WIDTH{1'b0}}};
      max_r <= '0;
      thr_r <= '0;
    end else if (ctl.accept && ctl.calibrate) begin
      min_r <= min_nxt;
      max_r <= max_nxt;
      thr_r <= thr_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/lscs_merge.sv =====
// Merge stage: combines lane flags into pattern and direction, decodes the
// command into the next response byte, and holds the result register.
// Depends on lscs_pkg.
`default_nettype none

module lscs_merge #(
  parameter int SAMPLE_WIDTH = lscs_pkg::SAMPLE_WIDTH_DEF
) (
  input  wire logic                                       clk,
  input  wire logic                                       rst_n,
  input  wire lscs_pkg::xfer_ctl_t                        ctl,
  input  wire logic [lscs_pkg::BYTE_W-1:0]                cmd,
  input  wire logic [lscs_pkg::NUM_CH-1:0][SAMPLE_WIDTH-1:0] samples,
  input  wire logic [lscs_pkg::NUM_CH-1:0]                above,
  input  wire logic                                       out_stall,
  output logic                                            out_valid,
  output logic [lscs_pkg::BYTE_W-1:0]                     out_tx_byte,
  output logic [lscs_pkg::PAT_W-1:0]                      out_pattern,
  output logic [lscs_pkg::DIR_W-1:0]                      out_direction
);

  logic [lscs_pkg::BYTE_W-1:0] resp_r, resp_nxt;
  lscs_pkg::dir_t              dir_r, dir_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic [lscs_pkg::BYTE_W-1:0] tx_r;
  logic [lscs_pkg::PAT_W-1:0]  pat_r;
  lscs_pkg::dir_t              odir_r;

  logic [lscs_pkg::BYTE_W-1:0]   off;
  logic [lscs_pkg::CH_IDX_W-1:0] ch;
  logic [SAMPLE_WIDTH-1:0]       sel;
  logic [SAMPLE_WIDTH+7:0]       sel_ext;

  always_comb begin
    dir_nxt = dir_r;
    case (above)
      lscs_pkg::PAT_LOST:     dir_nxt = lscs_pkg::DIR_LOST;
      lscs_pkg::PAT_STRAIGHT: dir_nxt = lscs_pkg::DIR_STRAIGHT;
      lscs_pkg::PAT_RIGHT:    dir_nxt = lscs_pkg::DIR_RIGHT;
      lscs_pkg::PAT_LEFT:     dir_nxt = lscs_pkg::DIR_LEFT;
      lscs_pkg::PAT_CROSS:    dir_nxt = lscs_pkg::DIR_CROSS;
      default:                dir_nxt = dir_r;
    endcase
  end

  always_comb begin
    off      = cmd - lscs_pkg::CMD_CH_FIRST;
    ch       = off[lscs_pkg::CH_IDX_W:1];
    sel      = samples[ch];
    sel_ext  = {8'h00, sel};
    resp_nxt = resp_r;
    if (cmd == lscs_pkg::CMD_PING) begin
      resp_nxt = lscs_pkg::RESP_ACK;
    end else if (cmd >= lscs_pkg::CMD_CH_FIRST && cmd <= lscs_pkg::CMD_CH_LAST) begin
      resp_nxt = off[0] ? sel_ext[15:8] : sel[7:0];
    end else if (cmd == lscs_pkg::CMD_CALIBRATE) begin
      resp_nxt = lscs_pkg::RESP_ACK;
    end
  end

  assign out_valid_nxt = ctl.accept | (out_valid_r & out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      resp_r      <= lscs_pkg::RESP_RESET;
      dir_r       <= lscs_pkg::DIR_NONE;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (ctl.accept) begin
        resp_r <= resp_nxt;
        dir_r  <= dir_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.accept) begin
      tx_r   <= resp_r;
      pat_r  <= above;
      odir_r <= dir_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_tx_byte   = tx_r;
  assign out_pattern   = pat_r;
  assign out_direction = odir_r;

endmodule

`default_nettype wire

// ===== hdl/line_sensor_calibrating_slave_core.sv =====
// Top level of the line sensor calibrating slave.
// Instantiates one lscs_lane per sensor channel and the lscs_merge stage.
// Depends on lscs_pkg, lscs_lane, lscs_merge.
`default_nettype none

// Each transfer carries a command byte and three sensor samples and yields
// one result in the cycle after it is taken: the response byte loaded by the
// previous command, the above-threshold pattern and the line direction code. A
// new transfer is taken every cycle; the three lanes compare and calibrate in
// parallel within that cycle, and a single result register sits between the
// lanes and the output, so input stalls only while that register holds a
// result that the output side is stalling.

module line_sensor_calibrating_slave_core #(
  parameter int SAMPLE_WIDTH = lscs_pkg::SAMPLE_WIDTH_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic [lscs_pkg::BYTE_W-1:0]  in_rx_byte,
  input  wire logic [SAMPLE_WIDTH-1:0]      in_sample_ch0,
  input  wire logic [SAMPLE_WIDTH-1:0]      in_sample_ch1,
  input  wire logic [SAMPLE_WIDTH-1:0]      in_sample_ch2,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic [lscs_pkg::BYTE_W-1:0]       out_tx_byte,
  output logic [lscs_pkg::PAT_W-1:0]        out_pattern,
  output logic [lscs_pkg::DIR_W-1:0]        out_direction
);

  lscs_pkg::xfer_ctl_t                              ctl;
  logic [lscs_pkg::NUM_CH-1:0][SAMPLE_WIDTH-1:0]    samples;
  logic [lscs_pkg::NUM_CH-1:0]                      above;

  assign in_stall      = out_valid & out_stall;
  assign ctl.accept    = in_valid & ~in_stall;
  assign ctl.calibrate = (in_rx_byte == lscs_pkg::CMD_CALIBRATE);

  assign samples[0] = in_sample_ch0;
  assign samples[1] = in_sample_ch1;
  assign samples[2] = in_sample_ch2;

  for (genvar i = 0; i < lscs_pkg::NUM_CH; i++) begin : g_lane
    lscs_lane #(
      .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_lane (
      .clk    (clk),
      .rst_n  (rst_n),
      .ctl    (ctl),
      .sample (samples[i]),
      .above  (above[i])
    );
  end

  lscs_merge #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_merge (
    .clk           (clk),
    .rst_n         (rst_n),
    .ctl           (ctl),
    .cmd           (in_rx_byte),
    .samples       (samples),
    .above         (above),
    .out_stall     (out_stall),
    .out_valid     (out_valid),
    .out_tx_byte   (out_tx_byte),
    .out_pattern   (out_pattern),
    .out_direction (out_direction)
  );

endmodule

`default_nettype wire

// ===== hdl/lscs_checker.sv =====
// Port-level checks for line_sensor_calibrating_slave_core, and the bind
// that attaches them. Depends on lscs_pkg.
`default_nettype none

module lscs_checker (
  input wire logic                        clk,
  input wire logic                        rst_n,
  input wire logic                        in_valid,
  input wire logic                        in_stall,
  input wire logic                        out_valid,
  input wire logic                        out_stall,
  input wire logic [lscs_pkg::BYTE_W-1:0] out_tx_byte,
  input wire logic [lscs_pkg::PAT_W-1:0]  out_pattern,
  input wire logic [lscs_pkg::DIR_W-1:0]  out_direction
);

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> out_valid)
    else $error("transfer accepted without a result next cycle");

  a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled while result register free");

  a_dir_decode: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |->
      (out_pattern != lscs_pkg::PAT_LOST     || out_direction == lscs_pkg::DIR_LOST) &&
      (out_pattern != lscs_pkg::PAT_STRAIGHT || out_direction == lscs_pkg::DIR_STRAIGHT) &&
      (out_pattern != lscs_pkg::PAT_RIGHT    || out_direction == lscs_pkg::DIR_RIGHT) &&
      (out_pattern != lscs_pkg::PAT_LEFT     || out_direction == lscs_pkg::DIR_LEFT) &&
      (out_pattern != lscs_pkg::PAT_CROSS    || out_direction == lscs_pkg::DIR_CROSS))
    else $error("direction does not match pattern");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_tx_byte) &&
      $stable(out_pattern) && $stable(out_direction))
    else $error("stalled result changed");

endmodule

bind line_sensor_calibrating_slave_core lscs_checker u_lscs_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_tx_byte   (out_tx_byte),
  .out_pattern   (out_pattern),
  .out_direction (out_direction)
);

`default_nettype wire

// ===== tb/sv/tb_line_sensor_calibrating_slave_core.sv =====
// Self-checking testbench for line_sensor_calibrating_slave_core.
// Predicts response byte, threshold pattern and direction per transfer.
// Depends on lscs_pkg and the core RTL.
module tb_line_sensor_calibrating_slave_core;
  import lscs_pkg::*;

  localparam int SW          = SAMPLE_WIDTH_DEF;
  localparam int SMP_MAX     = (1 << SW) - 1;
  localparam int RAND_ITEMS  = 800;
  localparam int LONG_HOLD   = 80;
  localparam int CYCLE_LIMIT = 100000;

  typedef struct packed {
    logic [BYTE_W-1:0]          cmd;
    logic [NUM_CH-1:0][SW-1:0]  smp;
    logic                       drain;
  } xfer_t;

  typedef struct packed {
    logic [BYTE_W-1:0] tx;
    logic [PAT_W-1:0]  pat;
    dir_t              dir;
  } report_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [BYTE_W-1:0] in_rx_byte = '0;
  logic [SW-1:0] in_sample_ch0 = '0;
  logic [SW-1:0] in_sample_ch1 = '0;
  logic [SW-1:0] in_sample_ch2 = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [BYTE_W-1:0] out_tx_byte;
  logic [PAT_W-1:0] out_pattern;
  logic [DIR_W-1:0] out_direction;

  line_sensor_calibrating_slave_core #(.SAMPLE_WIDTH(SW)) dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_rx_byte    (in_rx_byte),
    .in_sample_ch0 (in_sample_ch0),
    .in_sample_ch1 (in_sample_ch1),
    .in_sample_ch2 (in_sample_ch2),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_tx_byte   (out_tx_byte),
    .out_pattern   (out_pattern),
    .out_direction (out_direction)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predicted sensor state
  logic [BYTE_W-1:0] resp_byte = RESP_RESET;
  logic [SW:0]       ch_min [NUM_CH] = '{default: (SW+1)'(1 << SW)};
  logic [SW-1:0]     ch_max [NUM_CH] = '{default: '0};
  logic [SW-1:0]     ch_thr [NUM_CH] = '{default: '0};
  dir_t              line_dir = DIR_NONE;

  xfer_t   xfer_q [$];
  report_t sensor_reports_q [$];
  xfer_t   cur;
  int      errors = 0;
  int      cycles = 0;

  function automatic report_t apply_transfer(xfer_t x);
    report_t r;
    logic [PAT_W-1:0] pat;
    logic [BYTE_W-1:0] off;
    logic [SW-1:0] v;
    logic [SW+1:0] sum;
    r.tx = resp_byte;
    pat = '0;
    for (int i = 0; i < NUM_CH; i++)
      if (x.smp[i] > ch_thr[i]) pat[i] = 1'b1;
    case (pat)
      PAT_LOST:     line_dir = DIR_LOST;
      PAT_STRAIGHT: line_dir = DIR_STRAIGHT;
      PAT_RIGHT:    line_dir = DIR_RIGHT;
      PAT_LEFT:     line_dir = DIR_LEFT;
      PAT_CROSS:    line_dir = DIR_CROSS;
      default:      line_dir = line_dir;
    endcase
    if (x.cmd == CMD_PING) begin
      resp_byte = RESP_ACK;
    end else if (x.cmd >= CMD_CH_FIRST && x.cmd <= CMD_CH_LAST) begin
      off = x.cmd - CMD_CH_FIRST;
      v = x.smp[off[2:1]];
      resp_byte = off[0] ? BYTE_W'(v >> 8) : v[7:0];
    end else if (x.cmd == CMD_CALIBRATE) begin
      for (int i = 0; i < NUM_CH; i++) begin
        if ({1'b0, x.smp[i]} < ch_min[i]) ch_min[i] = {1'b0, x.smp[i]};
        if (x.smp[i] > ch_max[i]) ch_max[i] = x.smp[i];
        sum = {1'b0, ch_min[i]} + {2'b00, ch_max[i]};
        ch_thr[i] = sum[SW:1];
      end
      resp_byte = RESP_ACK;
    end
    r.pat = pat;
    r.dir = line_dir;
    return r;
  endfunction

  task automatic add_xfer(logic [BYTE_W-1:0] cmd, int s0, int s1, int s2, bit drain);
    xfer_t x;
    x.cmd = cmd;
    x.smp[0] = SW'(s0);
    x.smp[1] = SW'(s1);
    x.smp[2] = SW'(s2);
    x.drain = drain;
    xfer_q.push_back(x);
  endtask

  function automatic int draw_sample(int lo, int hi);
    if ($urandom_range(0, 3) == 0)
      return $urandom_range(0, 1) ? SMP_MAX : 0;
    return $urandom_range(lo, hi);
  endfunction

  task automatic flag_mismatch(string what, int expv, int gotv);
    errors++;
    if (errors <= 10)
      $display("mismatch %s: expected %0h got %0h at cycle %0d", what, expv, gotv, cycles);
  endtask

  // Sender
  int  send_gap = 0;
  int  n_sent = 0;
  bit  send_calm = 1'b0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        sensor_reports_q.push_back(apply_transfer(cur));
        n_sent++;
        if (n_sent % 64 == 0) send_calm = ($urandom_range(0, 3) == 0);
        send_gap = send_calm ? 0 : $urandom_range(0, 5);
      end
      if (!(in_valid && in_stall)) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (xfer_q.size() > 0 &&
                     (!xfer_q[0].drain || sensor_reports_q.size() == 0)) begin
          cur = xfer_q.pop_front();
          in_valid      <= 1'b1;
          in_rx_byte    <= cur.cmd;
          in_sample_ch0 <= cur.smp[0];
          in_sample_ch1 <= cur.smp[1];
          in_sample_ch2 <= cur.smp[2];
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver
  int      recv_gap = 0;
  int      hold_left = 0;
  int      n_seen = 0;
  bit      recv_calm = 1'b0;
  report_t want;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (sensor_reports_q.size() == 0) begin
          flag_mismatch("unexpected result tx_byte", 0, out_tx_byte);
        end else begin
          want = sensor_reports_q.pop_front();
          if (out_tx_byte !== want.tx) flag_mismatch("tx_byte", want.tx, out_tx_byte);
          if (out_pattern !== want.pat) flag_mismatch("pattern", want.pat, out_pattern);
          if (out_direction !== want.dir) flag_mismatch("direction", want.dir, out_direction);
        end
        n_seen++;
        if (n_seen == 200) hold_left = LONG_HOLD;
        if (n_seen % 64 == 0) recv_calm = ($urandom_range(0, 3) == 0);
        recv_gap = recv_calm ? 0 : $urandom_range(0, 5);
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (recv_gap > 0) begin
        recv_gap--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb_line_sensor_calibrating_slave_core failed");
      $finish;
    end
  end

  initial begin
    int pick;
    int lo;
    int hi;
    int n_items;
    logic [BYTE_W-1:0] cmd;
    // Directed: all commands, sample extremes, every pattern class
    add_xfer(CMD_PING, 5, 0, 0, 1'b0);
    add_xfer(CMD_CH_FIRST, SMP_MAX, 0, 0, 1'b0);
    add_xfer(BYTE_W'(CMD_CH_FIRST + 1), SMP_MAX, SMP_MAX, SMP_MAX, 1'b0);
    add_xfer(BYTE_W'(CMD_CH_FIRST + 2), 0, 'h2AA, 0, 1'b0);
    add_xfer(BYTE_W'(CMD_CH_FIRST + 3), 0, SMP_MAX, 0, 1'b0);
    add_xfer(BYTE_W'(CMD_CH_FIRST + 4), 0, 0, 'h155, 1'b0);
    add_xfer(CMD_CH_LAST, 0, 0, SMP_MAX, 1'b0);
    add_xfer(CMD_CALIBRATE, 512, 512, 512, 1'b0);
    add_xfer(CMD_CALIBRATE, 500, 520, 510, 1'b0);
    add_xfer(BYTE_W'(CMD_CH_FIRST - 1), 506, 516, 511, 1'b0);
    add_xfer(BYTE_W'(CMD_CH_LAST + 1), 507, 517, 512, 1'b0);
    add_xfer(BYTE_W'(CMD_CALIBRATE - 1), 0, SMP_MAX, 0, 1'b0);
    add_xfer(BYTE_W'(CMD_CALIBRATE + 1), SMP_MAX, SMP_MAX, 0, 1'b0);
    add_xfer(~CMD_PING, 0, SMP_MAX, SMP_MAX, 1'b0);
    add_xfer(BYTE_W'(CMD_CH_FIRST + 1), SMP_MAX, 0, 0, 1'b0);
    add_xfer(BYTE_W'(CMD_CH_FIRST + 3), 0, 0, SMP_MAX, 1'b0);
    add_xfer(CMD_PING, SMP_MAX, 0, SMP_MAX, 1'b0);
    add_xfer(CMD_CH_LAST, SMP_MAX, SMP_MAX, SMP_MAX, 1'b0);
    // Random: calibration window widens over the run
    for (int n = 0; n < RAND_ITEMS; n++) begin
      lo = (n * 2 / 3 > 400) ? 0 : 400 - n * 2 / 3;
      hi = (600 + n * 2 / 3 > SMP_MAX) ? SMP_MAX : 600 + n * 2 / 3;
      pick = $urandom_range(0, 9);
      if (pick == 0) cmd = CMD_PING;
      else if (pick <= 4) cmd = BYTE_W'($urandom_range(CMD_CH_FIRST, CMD_CH_LAST));
      else if (pick <= 6) cmd = CMD_CALIBRATE;
      else cmd = BYTE_W'($urandom_range(0, 255));
      if (cmd == CMD_CALIBRATE)
        add_xfer(cmd, $urandom_range(lo, hi), $urandom_range(lo, hi),
                 $urandom_range(lo, hi), n == 0 || n == 400);
      else
        add_xfer(cmd, draw_sample(0, SMP_MAX), draw_sample(0, SMP_MAX),
                 draw_sample(0, SMP_MAX), n == 0 || n == 400);
    end
    n_items = xfer_q.size();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    do @(posedge clk);
    while (n_seen < n_items);
    repeat (10) @(posedge clk);
    if (errors == 0 && xfer_q.size() == 0 && sensor_reports_q.size() == 0) begin
      $display("tb_line_sensor_calibrating_slave_core passed");
    end else begin
      $display("tb_line_sensor_calibrating_slave_core failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/lscs_pkg.sv
hdl/lscs_lane.sv
hdl/lscs_merge.sv
hdl/line_sensor_calibrating_slave_core.sv
hdl/lscs_checker.sv
tb/sv/tb_line_sensor_calibrating_slave_core.sv
